// ===== sv/idlmd_pkg.sv =====
`default_nettype none

package idlmd_pkg;

    localparam int NUM_SLOTS  = 4;
    localparam int REG_SLOTS  = 4;
    localparam int BYTE_W     = 8;
    localparam int REG_W      = 16;
    localparam int SLOT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [REG_W-1:0] MIN_LEN = REG_W'(2);

    // what one queued entry turns into on the output side
    typedef enum logic [1:0] {
        ENT_MSG,
        ENT_UNEXP,
        ENT_PAIR
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t       kind;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== sv/idlmd_front.sv =====
`default_nettype none

module idlmd_front
    import idlmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [BYTE_W-1:0]    rx_byte,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data,
    input  wire queue_status_t        q_status,
    output logic                      push,
    output entry_t                    push_entry
);

    logic [REG_W-1:0]  slot_id_reg  [REG_SLOTS];
    logic [REG_W-1:0]  slot_len_reg [REG_SLOTS];

    logic [BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic              held_valid_reg, held_valid_next;
    logic              in_msg_reg, in_msg_next;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [REG_W-1:0]  remaining_reg, remaining_next;

    logic              accept;
    logic              hit_found;
    logic [SLOT_W-1:0] hit_idx;
    logic [REG_W-1:0]  hit_len;
    logic [REG_W-1:0]  rx_id;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign rx_id    = {rx_byte, held_byte_reg};

    // slot registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < REG_SLOTS; k++)
            begin
                slot_id_reg[k]  <= '0;
                slot_len_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index[0])
                slot_len_reg[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
            else
                slot_id_reg[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
        end
    end

    // parallel id compare, lowest enabled slot wins
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--)
        begin
            if (slot_len_reg[k] >= MIN_LEN && slot_id_reg[k] == rx_id)
            begin
                hit_found = 1'b1;
                hit_idx   = SLOT_W'(k);
            end
        end
    end

    assign hit_len = slot_len_reg[hit_idx];

    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        in_msg_next     = in_msg_reg;
        cur_slot_next   = cur_slot_reg;
        remaining_next  = remaining_reg;
        push            = 1'b0;
        push_entry.kind  = ENT_MSG;
        push_entry.byte0 = rx_byte;
        push_entry.byte1 = rx_byte;
        push_entry.slot  = cur_slot_reg;
        push_entry.last  = 1'b0;
        if (accept)
        begin
            if (in_msg_reg)
            begin
                push            = 1'b1;
                push_entry.last = (remaining_reg <= REG_W'(1));
                if (remaining_reg != '0)
                    remaining_next = remaining_reg - REG_W'(1);
                if (remaining_reg <= REG_W'(1))
                    in_msg_next = 1'b0;
            end
            else if (!held_valid_reg)
            begin
                held_byte_next  = rx_byte;
                held_valid_next = 1'b1;
            end
            else if (hit_found)
            begin
                push             = 1'b1;
                push_entry.kind  = ENT_PAIR;
                push_entry.byte0 = held_byte_reg;
                push_entry.slot  = hit_idx;
                push_entry.last  = (hit_len == MIN_LEN);
                held_valid_next  = 1'b0;
                held_byte_next   = '0;
                cur_slot_next    = hit_idx;
                if (hit_len > MIN_LEN)
                begin
                    remaining_next = hit_len - MIN_LEN;
                    in_msg_next    = 1'b1;
                end
                else
                begin
                    remaining_next = '0;
                    in_msg_next    = 1'b0;
                end
            end
            else
            begin
                push             = 1'b1;
                push_entry.kind  = ENT_UNEXP;
                push_entry.byte0 = held_byte_reg;
                push_entry.slot  = '0;
                held_byte_next   = rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            in_msg_reg     <= 1'b0;
            cur_slot_reg   <= '0;
            remaining_reg  <= '0;
        end
        else
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            in_msg_reg     <= in_msg_next;
            cur_slot_reg   <= cur_slot_next;
            remaining_reg  <= remaining_next;
        end
    end

`ifndef SYNTHESIS
    a_msg_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_msg_reg |-> remaining_reg != '0)
        else $error("message active with zero bytes remaining");

    a_no_hold_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
        in_msg_reg |-> !held_valid_reg)
        else $error("byte held while inside a message");
`endif

endmodule

`default_nettype wire

// ===== sv/idlmd_queue.sv =====
`default_nettype none

module idlmd_queue
    import idlmd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output entry_t      head,
    output queue_status_t status
);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("entry pushed into full queue");
`endif

endmodule

`default_nettype wire

// ===== sv/idlmd_back.sv =====
`default_nettype none

module idlmd_back
    import idlmd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire entry_t        head,
    input  wire queue_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [BYTE_W-1:0]  out_byte,
    output logic               is_unexpected,
    output logic [SLOT_W-1:0]  slot_index,
    output logic               first_of_message,
    output logic               last_of_message
);

    logic              valid_reg, valid_next;
    logic              second_reg, second_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              unexp_reg, unexp_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              first_reg, first_next;
    logic              last_reg, last_next;
    logic              out_free;
    logic              load;

    assign out_free = !valid_reg || !out_stall;
    assign load     = out_free && !q_status.empty;

    always_comb
    begin
        valid_next  = valid_reg && out_stall;
        second_next = second_reg;
        pop         = 1'b0;
        byte_next   = byte_reg;
        unexp_next  = unexp_reg;
        slot_next   = slot_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            unique case (head.kind)
                ENT_MSG:
                begin
                    pop        = 1'b1;
                    byte_next  = head.byte0;
                    unexp_next = 1'b0;
                    slot_next  = head.slot;
                    first_next = 1'b0;
                    last_next  = head.last;
                end
                ENT_UNEXP:
                begin
                    pop        = 1'b1;
                    byte_next  = head.byte0;
                    unexp_next = 1'b1;
                    slot_next  = '0;
                    first_next = 1'b0;
                    last_next  = 1'b0;
                end
                ENT_PAIR:
                begin
                    unexp_next = 1'b0;
                    slot_next  = head.slot;
                    if (!second_reg)
                    begin
                        byte_next   = head.byte0;
                        first_next  = 1'b1;
                        last_next   = 1'b0;
                        second_next = 1'b1;
                    end
                    else
                    begin
                        pop         = 1'b1;
                        byte_next   = head.byte1;
                        first_next  = 1'b0;
                        last_next   = head.last;
                        second_next = 1'b0;
                    end
                end
                default:
                begin
                    pop        = 1'b1;
                    valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        unexp_reg <= unexp_next;
        slot_reg  <= slot_next;
        first_reg <= first_next;
        last_reg  <= last_next;
    end

    assign out_valid        = valid_reg;
    assign out_byte         = byte_reg;
    assign is_unexpected    = unexp_reg;
    assign slot_index       = slot_reg;
    assign first_of_message = first_reg;
    assign last_of_message  = last_reg;

`ifndef SYNTHESIS
    a_second_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> !q_status.empty && head.kind == ENT_PAIR)
        else $error("second id byte pending without a pair at the head");
`endif

endmodule

`default_nettype wire

// ===== sv/id_length_message_deframer_unit.sv =====
// path: a byte that yields a result is written into the queue, then loaded into the registered
//   output stage that drives out_valid; the second id byte of a match follows the first
// throughput: one input word per cycle while the queue is not full; the output stage drains one
//   word per cycle while out_stall is low, and an id match gives two output words from one entry
// reset: rst_n async active low clears slot registers, search state, queue and output valid
`default_nettype none

module id_length_message_deframer_unit
    import idlmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [BYTE_W-1:0]    rx_byte,
    // output channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [BYTE_W-1:0]         out_byte,
    output logic                      is_unexpected,
    output logic [SLOT_W-1:0]         slot_index,
    output logic                      first_of_message,
    output logic                      last_of_message,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data
);

    // front to queue
    logic          push;
    entry_t        push_entry;
    // queue to back
    entry_t        head;
    queue_status_t q_status;
    logic          pop;

    // front: holds the search state and the slot table, classifies each
    // received word as message data, an id match or an unexpected byte
    idlmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // short queue of classified entries, input stalls only when it is full
    idlmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // back: expands each entry into one or two output words through a
    // registered output stage
    idlmd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .q_status         (q_status),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .is_unexpected    (is_unexpected),
        .slot_index       (slot_index),
        .first_of_message (first_of_message),
        .last_of_message  (last_of_message)
    );

endmodule

`default_nettype wire
